// ===== design/tgpg_pkg.sv =====
`default_nettype none
package tgpg_pkg;

  localparam int CMD_W      = 15;
  localparam int AMP_W      = 13;
  localparam int OFS_W      = 14;
  localparam int STEP_W     = 15;
  localparam int LAG_W      = 16;
  localparam int ROM_W      = 13;
  localparam int COS_W      = 14;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int SUM_W      = 17;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AMP_FORE_HIP   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_AMP_HIND_HIP   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_AMP_FORE_KNEE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_AMP_HIND_KNEE  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_OFS_FORE_HIP   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_OFS_HIND_HIP   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_KNEE_LAG       = 3'd7;

  // register reset values
  localparam logic [STEP_W-1:0]       RST_PHASE_STEP    = 15'd131;
  localparam logic [AMP_W-1:0]        RST_AMP_FORE_HIP  = 13'd1502;
  localparam logic [AMP_W-1:0]        RST_AMP_HIND_HIP  = 13'd1502;
  localparam logic [AMP_W-1:0]        RST_AMP_FORE_KNEE = 13'd1502;
  localparam logic [AMP_W-1:0]        RST_AMP_HIND_KNEE = 13'd956;
  localparam logic signed [OFS_W-1:0] RST_OFS_FORE_HIP  = 14'sd0;
  localparam logic signed [OFS_W-1:0] RST_OFS_HIND_HIP  = 14'sd0;
  localparam logic [LAG_W-1:0]        RST_KNEE_LAG      = 16'd0;

  // knee command while the leg is not lifted
  localparam logic signed [CMD_W-1:0] KNEE_OFFSET = 15'sd0;

  // phase quadrants
  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;

  localparam logic signed [SUM_W-1:0] CMD_MAX = 17'sd16383;
  localparam logic signed [SUM_W-1:0] CMD_MIN = -17'sd16384;

  localparam longint HALF_PI_Q30 = 64'sd1686629713;
  localparam longint ONE_Q30     = 64'sd1073741824;

  typedef struct packed {
    logic [STEP_W-1:0]       phase_step;
    logic [AMP_W-1:0]        amp_fore_hip;
    logic [AMP_W-1:0]        amp_hind_hip;
    logic [AMP_W-1:0]        amp_fore_knee;
    logic [AMP_W-1:0]        amp_hind_knee;
    logic signed [OFS_W-1:0] offset_fore_hip;
    logic signed [OFS_W-1:0] offset_hind_hip;
    logic [LAG_W-1:0]        knee_lag;
  } cfg_t;

  function automatic logic signed [CMD_W-1:0] sat_cmd(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] c;
    c = v;
    if (v > CMD_MAX) begin
      c = CMD_MAX;
    end else if (v < CMD_MIN) begin
      c = CMD_MIN;
    end
    return c[CMD_W-1:0];
  endfunction

endpackage
`default_nettype wire

// ===== design/tgpg_cfg_regs.sv =====
`default_nettype none
module tgpg_cfg_regs
  import tgpg_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                       cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.phase_step      <= RST_PHASE_STEP;
      cfg.amp_fore_hip    <= RST_AMP_FORE_HIP;
      cfg.amp_hind_hip    <= RST_AMP_HIND_HIP;
      cfg.amp_fore_knee   <= RST_AMP_FORE_KNEE;
      cfg.amp_hind_knee   <= RST_AMP_HIND_KNEE;
      cfg.offset_fore_hip <= RST_OFS_FORE_HIP;
      cfg.offset_hind_hip <= RST_OFS_HIND_HIP;
      cfg.knee_lag        <= RST_KNEE_LAG;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PHASE_STEP:    cfg.phase_step      <= cfg_data[STEP_W-1:0];
        REG_AMP_FORE_HIP:  cfg.amp_fore_hip    <= cfg_data[AMP_W-1:0];
        REG_AMP_HIND_HIP:  cfg.amp_hind_hip    <= cfg_data[AMP_W-1:0];
        REG_AMP_FORE_KNEE: cfg.amp_fore_knee   <= cfg_data[AMP_W-1:0];
        REG_AMP_HIND_KNEE: cfg.amp_hind_knee   <= cfg_data[AMP_W-1:0];
        REG_OFS_FORE_HIP:  cfg.offset_fore_hip <= $signed(cfg_data[OFS_W-1:0]);
        REG_OFS_HIND_HIP:  cfg.offset_hind_hip <= $signed(cfg_data[OFS_W-1:0]);
        REG_KNEE_LAG:      cfg.knee_lag        <= cfg_data[LAG_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== design/tgpg_cos_lut.sv =====
`default_nettype none
module tgpg_cos_lut
  import tgpg_pkg::*;
#(
  parameter int PHASE_BITS        = 16,
  parameter int COS_TABLE_ENTRIES = 256
) (
  input  wire logic [PHASE_BITS-1:0] phase,
  output logic signed [COS_W-1:0]    cos_val
);

  localparam int QuarterBits = PHASE_BITS - 2;
  localparam int IdxW        = $clog2(COS_TABLE_ENTRIES + 1);
  localparam int ScaledW     = QuarterBits + IdxW;

  logic [ROM_W-1:0]       rom [0:COS_TABLE_ENTRIES];
  logic [1:0]             quad;
  logic [ScaledW-1:0]     scaled;
  logic [IdxW-1:0]        idx;
  logic [IdxW-1:0]        idx_mirror;
  logic [ROM_W-1:0]       mag;
  logic                   neg;

  // quarter-wave entry k: taylor series of cos in q30, rounded to q12
  for (genvar k = 0; k <= COS_TABLE_ENTRIES; k++) begin : g_rom
    localparam longint Th     = (HALF_PI_Q30 * longint'(k)) / longint'(COS_TABLE_ENTRIES);
    localparam longint Th2    = (Th * Th) / ONE_Q30;
    localparam longint Term1  = -Th2 / 64'sd2;
    localparam longint Term2  = -((Term1 * Th2) / ONE_Q30) / 64'sd12;
    localparam longint Term3  = -((Term2 * Th2) / ONE_Q30) / 64'sd30;
    localparam longint Term4  = -((Term3 * Th2) / ONE_Q30) / 64'sd56;
    localparam longint Term5  = -((Term4 * Th2) / ONE_Q30) / 64'sd90;
    localparam longint Term6  = -((Term5 * Th2) / ONE_Q30) / 64'sd132;
    localparam longint Term7  = -((Term6 * Th2) / ONE_Q30) / 64'sd182;
    localparam longint Term8  = -((Term7 * Th2) / ONE_Q30) / 64'sd240;
    localparam longint Term9  = -((Term8 * Th2) / ONE_Q30) / 64'sd306;
    localparam longint Term10 = -((Term9 * Th2) / ONE_Q30) / 64'sd380;
    localparam longint Term11 = -((Term10 * Th2) / ONE_Q30) / 64'sd462;
    localparam longint Term12 = -((Term11 * Th2) / ONE_Q30) / 64'sd552;
    localparam longint Term13 = -((Term12 * Th2) / ONE_Q30) / 64'sd650;
    localparam longint Term14 = -((Term13 * Th2) / ONE_Q30) / 64'sd756;
    localparam longint Sum    = ONE_Q30 + Term1 + Term2 + Term3 + Term4 + Term5 + Term6
                                + Term7 + Term8 + Term9 + Term10 + Term11 + Term12
                                + Term13 + Term14;
    localparam longint Clip   = (Sum < 0) ? 64'sd0 : Sum;
    localparam logic [ROM_W-1:0] Entry = ROM_W'((Clip + 64'sd131072) >>> 18);
    assign rom[k] = Entry;
  end

  assign quad       = phase[PHASE_BITS-1:QuarterBits];
  assign scaled     = ScaledW'(phase[QuarterBits-1:0]) * ScaledW'(COS_TABLE_ENTRIES);
  assign idx        = scaled[ScaledW-1:QuarterBits];
  assign idx_mirror = IdxW'(COS_TABLE_ENTRIES) - idx;

  always_comb begin
    case (quad)
      QUAD_0: begin
        mag = rom[idx];
        neg = 1'b0;
      end
      QUAD_1: begin
        mag = rom[idx_mirror];
        neg = 1'b1;
      end
      QUAD_2: begin
        mag = rom[idx];
        neg = 1'b1;
      end
      default: begin
        mag = rom[idx_mirror];
        neg = 1'b0;
      end
    endcase
  end

  assign cos_val = neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});

endmodule
`default_nettype wire

// ===== design/tgpg_hip_pair.sv =====
`default_nettype none
module tgpg_hip_pair
  import tgpg_pkg::*;
(
  input  wire logic [AMP_W-1:0]        amp,
  input  wire logic signed [OFS_W-1:0] offset,
  input  wire logic signed [COS_W-1:0] cos_val,
  output logic signed [CMD_W-1:0]      cmd_ph,
  output logic signed [CMD_W-1:0]      cmd_de
);

  localparam int ProdW = AMP_W + COS_W;

  logic signed [ProdW-1:0] prod;
  logic signed [ProdW-1:0] prod_neg;
  logic signed [ProdW-1:0] rnd_ph;
  logic signed [ProdW-1:0] rnd_de;
  logic signed [CMD_W-1:0] q_ph;
  logic signed [CMD_W-1:0] q_de;
  logic signed [SUM_W-1:0] sum_ph;
  logic signed [SUM_W-1:0] sum_de;

  // antiphase cosine is the exact negation, so one product serves both legs
  assign prod     = ProdW'($signed({1'b0, amp})) * ProdW'(cos_val);
  assign prod_neg = -prod;

  // round half up then floor
  assign rnd_ph = prod + ProdW'(2048);
  assign rnd_de = prod_neg + ProdW'(2048);
  assign q_ph   = $signed(rnd_ph[ProdW-1:12]);
  assign q_de   = $signed(rnd_de[ProdW-1:12]);

  assign sum_ph = SUM_W'(q_ph) + SUM_W'(offset);
  assign sum_de = SUM_W'(q_de) + SUM_W'(offset);

  assign cmd_ph = sat_cmd(sum_ph);
  assign cmd_de = sat_cmd(sum_de);

endmodule
`default_nettype wire

// ===== design/trot_gait_pattern_generator_core.sv =====
`default_nettype none
// path: an accepted tick passes the input phase register, the cosine/knee register
//   and the command register, which holds its result
// throughput: one tick per cycle while the receiver does not stall the output
// reset: synchronous, clears the phase, the pipeline valids and loads the
//   register defaults; configuration writes are always ready
module trot_gait_pattern_generator_core
  import tgpg_pkg::*;
#(
  parameter int PHASE_BITS        = 16,
  parameter int COS_TABLE_ENTRIES = 256
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // configuration write channel
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  // tick request channel
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic                  restart,
  // command request channel
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic signed [CMD_W-1:0]    left_fore_hip_cmd,
  output logic signed [CMD_W-1:0]    right_fore_hip_cmd,
  output logic signed [CMD_W-1:0]    left_hind_hip_cmd,
  output logic signed [CMD_W-1:0]    right_hind_hip_cmd,
  output logic signed [CMD_W-1:0]    left_fore_knee_cmd,
  output logic signed [CMD_W-1:0]    right_fore_knee_cmd,
  output logic signed [CMD_W-1:0]    left_hind_knee_cmd,
  output logic signed [CMD_W-1:0]    right_hind_knee_cmd
);

  localparam logic [PHASE_BITS-1:0] HalfTurn = {1'b1, {(PHASE_BITS - 1){1'b0}}};

  cfg_t cfg;

  // phase accumulator and turn-unit scaling
  logic [PHASE_BITS-1:0] gait_phase;
  logic [PHASE_BITS-1:0] phase_now;
  logic [PHASE_BITS-1:0] step_units;
  logic [PHASE_BITS-1:0] lag_units;
  logic [LAG_W-1:0]      step16;

  // pipeline control
  logic in_accept;
  logic s1_ready;
  logic s2_ready;
  logic out_ready;
  logic s1_valid;
  logic s2_valid;

  // stage 1: phase of this tick
  logic [PHASE_BITS-1:0]   s1_phase;
  logic [PHASE_BITS-1:0]   knee_ph;
  logic [PHASE_BITS-1:0]   knee_de;
  logic signed [COS_W-1:0] cos_now;

  // stage 2: cosine and knee lift flags
  logic signed [COS_W-1:0] s2_cos;
  logic                    s2_lift_ph;
  logic                    s2_lift_de;

  logic signed [CMD_W-1:0] fore_ph;
  logic signed [CMD_W-1:0] fore_de;
  logic signed [CMD_W-1:0] hind_ph;
  logic signed [CMD_W-1:0] hind_de;
  logic signed [CMD_W-1:0] fore_knee_up;
  logic signed [CMD_W-1:0] hind_knee_up;

  // config registers, always ready
  assign cfg_ready = 1'b1;

  tgpg_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // 2^-16 turn units brought to the accumulator width
  assign step16 = LAG_W'(cfg.phase_step);

  if (PHASE_BITS >= LAG_W) begin : g_units_wide
    logic [PHASE_BITS-1:0] step_ext;
    logic [PHASE_BITS-1:0] lag_ext;
    assign step_ext   = PHASE_BITS'(step16);
    assign lag_ext    = PHASE_BITS'(cfg.knee_lag);
    assign step_units = step_ext << (PHASE_BITS - LAG_W);
    assign lag_units  = lag_ext << (PHASE_BITS - LAG_W);
  end else begin : g_units_narrow
    logic [LAG_W-1:0] step_sh;
    logic [LAG_W-1:0] lag_sh;
    assign step_sh    = step16 >> (LAG_W - PHASE_BITS);
    assign lag_sh     = cfg.knee_lag >> (LAG_W - PHASE_BITS);
    assign step_units = step_sh[PHASE_BITS-1:0];
    assign lag_units  = lag_sh[PHASE_BITS-1:0];
  end

  // each stage moves on when it is empty or the next one takes its item
  assign out_ready = !out_valid || !out_stall;
  assign s2_ready  = !s2_valid || out_ready;
  assign s1_ready  = !s1_valid || s2_ready;
  assign in_stall  = !s1_ready;
  assign in_accept = in_valid && s1_ready;

  // restart clears the phase before this tick's commands
  assign phase_now = restart ? '0 : gait_phase;

  always_ff @(posedge clk) begin
    if (rst) begin
      gait_phase <= '0;
      s1_valid   <= 1'b0;
      s2_valid   <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (in_accept) begin
        gait_phase <= phase_now + step_units;
      end
      if (s1_ready) begin
        s1_valid <= in_valid;
      end
      if (s2_ready) begin
        s2_valid <= s1_valid;
      end
      if (out_ready) begin
        out_valid <= s2_valid;
      end
    end
  end

  // stage 1 work: cosine of the tick phase and the knee windows
  tgpg_cos_lut #(
    .PHASE_BITS        (PHASE_BITS),
    .COS_TABLE_ENTRIES (COS_TABLE_ENTRIES)
  ) u_cos_lut (
    .phase   (s1_phase),
    .cos_val (cos_now)
  );

  // lagged knee phase, the diagonal pair is a half turn on
  assign knee_ph = s1_phase + lag_units;
  assign knee_de = knee_ph + HalfTurn;

  // stage 2 work: hip products, knee selection
  tgpg_hip_pair u_hip_fore (
    .amp     (cfg.amp_fore_hip),
    .offset  (cfg.offset_fore_hip),
    .cos_val (s2_cos),
    .cmd_ph  (fore_ph),
    .cmd_de  (fore_de)
  );

  tgpg_hip_pair u_hip_hind (
    .amp     (cfg.amp_hind_hip),
    .offset  (cfg.offset_hind_hip),
    .cos_val (s2_cos),
    .cmd_ph  (hind_ph),
    .cmd_de  (hind_de)
  );

  // knee lifted by its step height while in the first half turn
  assign fore_knee_up = KNEE_OFFSET + $signed(CMD_W'(cfg.amp_fore_knee));
  assign hind_knee_up = KNEE_OFFSET + $signed(CMD_W'(cfg.amp_hind_knee));

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_phase <= phase_now;
    end
    if (s2_ready && s1_valid) begin
      s2_cos     <= cos_now;
      s2_lift_ph <= (knee_ph <= HalfTurn);
      s2_lift_de <= (knee_de <= HalfTurn);
    end
    if (out_ready && s2_valid) begin
      left_fore_hip_cmd   <= fore_ph;
      right_fore_hip_cmd  <= fore_de;
      left_hind_hip_cmd   <= hind_de;
      right_hind_hip_cmd  <= hind_ph;
      left_fore_knee_cmd  <= s2_lift_ph ? fore_knee_up : KNEE_OFFSET;
      right_fore_knee_cmd <= s2_lift_de ? fore_knee_up : KNEE_OFFSET;
      left_hind_knee_cmd  <= s2_lift_de ? hind_knee_up : KNEE_OFFSET;
      right_hind_knee_cmd <= s2_lift_ph ? hind_knee_up : KNEE_OFFSET;
    end
  end

endmodule
`default_nettype wire

// ===== bench/tb.sv =====
`default_nettype none
module tb;
  import tgpg_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int          PH_W        = 16;
  localparam int          COS_ENTRIES = 256;
  localparam logic [15:0] HALF_TURN   = 16'h8000;
  localparam longint      HALF_PI_FX  = 64'sd1686629713;
  localparam longint      UNIT_FX     = 64'sd1073741824;
  localparam int          CYCLE_LIMIT = 400000;
  localparam int          RANDOM_TICKS = 1950;
  localparam int          PRINT_CAP   = 40;

  // the eight joint commands of one tick, in port order
  typedef struct packed {
    logic signed [CMD_W-1:0] lf_hip;
    logic signed [CMD_W-1:0] rf_hip;
    logic signed [CMD_W-1:0] lh_hip;
    logic signed [CMD_W-1:0] rh_hip;
    logic signed [CMD_W-1:0] lf_knee;
    logic signed [CMD_W-1:0] rf_knee;
    logic signed [CMD_W-1:0] lh_knee;
    logic signed [CMD_W-1:0] rh_knee;
  } joint_cmds_t;

  // receiver back-pressure styles
  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HALF,
    STALL_HEAVY
  } stall_mode_t;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         cfg_valid = 1'b0;
  logic                         cfg_ready;
  logic [CFG_IDX_W-1:0]         cfg_index = '0;
  logic [CFG_DATA_W-1:0]        cfg_data = '0;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic                         restart = 1'b0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic signed [CMD_W-1:0]      left_fore_hip_cmd;
  logic signed [CMD_W-1:0]      right_fore_hip_cmd;
  logic signed [CMD_W-1:0]      left_hind_hip_cmd;
  logic signed [CMD_W-1:0]      right_hind_hip_cmd;
  logic signed [CMD_W-1:0]      left_fore_knee_cmd;
  logic signed [CMD_W-1:0]      right_fore_knee_cmd;
  logic signed [CMD_W-1:0]      left_hind_knee_cmd;
  logic signed [CMD_W-1:0]      right_hind_knee_cmd;

  // predictor state: shadow registers, phase accumulator, cosine table
  cfg_t                         gait_cfg;
  logic [PH_W-1:0]              model_phase;
  int                           cos_tab [0:COS_ENTRIES];

  // ticks waiting to be sent, command sets waiting to come back
  bit                           tick_queue [$];
  joint_cmds_t                  due_cmds [$];

  int                           cycle_count = 0;
  int                           err_count = 0;
  int                           ticks_sent = 0;
  int                           restarts_sent = 0;
  int                           cmds_checked = 0;
  int                           settings_run = 0;
  int                           burst_left = 0;
  int                           gap_left = 0;
  int                           stall_left = 0;
  stall_mode_t                  stall_mode = STALL_NONE;

  trot_gait_pattern_generator_core i_dut (
    .clk                 (clk),
    .rst                 (rst),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .restart             (restart),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .left_fore_hip_cmd   (left_fore_hip_cmd),
    .right_fore_hip_cmd  (right_fore_hip_cmd),
    .left_hind_hip_cmd   (left_hind_hip_cmd),
    .right_hind_hip_cmd  (right_hind_hip_cmd),
    .left_fore_knee_cmd  (left_fore_knee_cmd),
    .right_fore_knee_cmd (right_fore_knee_cmd),
    .left_hind_knee_cmd  (left_hind_knee_cmd),
    .right_hind_knee_cmd (right_hind_knee_cmd)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // quarter-wave entry k: taylor series of cos in q30, rounded to q12
  function automatic int quarter_cos(int k);
    longint ang;
    longint ang_sq;
    longint term;
    longint acc;
    ang    = (HALF_PI_FX * longint'(k)) / longint'(COS_ENTRIES);
    ang_sq = (ang * ang) / UNIT_FX;
    term   = UNIT_FX;
    acc    = UNIT_FX;
    for (int n = 0; n < 14; n++) begin
      term = -((term * ang_sq) / UNIT_FX) / longint'((2 * n + 1) * (2 * n + 2));
      acc  = acc + term;
    end
    if (acc < 0) begin
      acc = 0;
    end
    return int'((acc + 64'sd131072) >>> 18);
  endfunction

  // full-turn cosine from the quarter table by symmetry
  function automatic int cos_of(logic [PH_W-1:0] p);
    int idx;
    idx = (int'(p[PH_W-3:0]) * COS_ENTRIES) >> (PH_W - 2);
    case (p[PH_W-1:PH_W-2])
      QUAD_0: return cos_tab[idx];
      QUAD_1: return -cos_tab[COS_ENTRIES - idx];
      QUAD_2: return -cos_tab[idx];
      default: return cos_tab[COS_ENTRIES - idx];
    endcase
  endfunction

  function automatic logic signed [CMD_W-1:0] clamp_cmd(longint v);
    longint c;
    c = v;
    if (c > 16383) begin
      c = 16383;
    end else if (c < -16384) begin
      c = -16384;
    end
    return c[CMD_W-1:0];
  endfunction

  // amp * cos in q12, round half toward plus infinity, then add the centre
  function automatic logic signed [CMD_W-1:0] hip_cmd(logic [AMP_W-1:0] amp,
                                                      logic signed [OFS_W-1:0] ofs,
                                                      logic [PH_W-1:0] p);
    longint prod;
    prod = longint'(amp) * longint'(cos_of(p)) + 64'sd2048;
    return clamp_cmd((prod >>> 12) + longint'(ofs));
  endfunction

  // lifted while the lagged phase is in the first half turn, end point included
  function automatic logic signed [CMD_W-1:0] knee_cmd(logic [AMP_W-1:0] amp,
                                                       logic [PH_W-1:0] p);
    longint v;
    v = longint'(KNEE_OFFSET);
    if (p <= HALF_TURN) begin
      v = v + longint'(amp);
    end
    return clamp_cmd(v);
  endfunction

  function automatic joint_cmds_t gait_commands(logic [PH_W-1:0] ph);
    joint_cmds_t     r;
    logic [PH_W-1:0] anti;
    logic [PH_W-1:0] ph_lag;
    logic [PH_W-1:0] anti_lag;
    anti     = ph + HALF_TURN;
    ph_lag   = ph + gait_cfg.knee_lag;
    anti_lag = anti + gait_cfg.knee_lag;
    r.lf_hip  = hip_cmd(gait_cfg.amp_fore_hip, gait_cfg.offset_fore_hip, ph);
    r.rf_hip  = hip_cmd(gait_cfg.amp_fore_hip, gait_cfg.offset_fore_hip, anti);
    r.lh_hip  = hip_cmd(gait_cfg.amp_hind_hip, gait_cfg.offset_hind_hip, anti);
    r.rh_hip  = hip_cmd(gait_cfg.amp_hind_hip, gait_cfg.offset_hind_hip, ph);
    r.lf_knee = knee_cmd(gait_cfg.amp_fore_knee, ph_lag);
    r.rf_knee = knee_cmd(gait_cfg.amp_fore_knee, anti_lag);
    r.lh_knee = knee_cmd(gait_cfg.amp_hind_knee, anti_lag);
    r.rh_knee = knee_cmd(gait_cfg.amp_hind_knee, ph_lag);
    return r;
  endfunction

  // one accepted tick: optional restart, commands from the phase, then advance
  task automatic advance_gait(bit clear_phase);
    if (clear_phase) begin
      model_phase = '0;
      restarts_sent++;
    end
    due_cmds.push_back(gait_commands(model_phase));
    model_phase = model_phase + PH_W'(gait_cfg.phase_step);
    ticks_sent++;
  endtask

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(string msg);
    err_count++;
    if (err_count <= PRINT_CAP) begin
      $display("mismatch, cycle %0d, command set %0d: %s", cycle_count, cmds_checked, msg);
    end
  endtask

  task automatic check_joint(string name, logic signed [CMD_W-1:0] got,
                             logic signed [CMD_W-1:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
    end
  endtask

  // ---------------------------------------------------------------------------
  // tick driver: bursts of random length separated by random gaps
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      in_valid   <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      if (in_valid && !in_stall) begin
        advance_gait(restart);
        void'(tick_queue.pop_front());
      end
      if (in_valid && in_stall) begin
        // stalled: hold the request as it is
      end else if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (tick_queue.size() > 0) begin
        in_valid <= 1'b1;
        restart  <= tick_queue[0];
        if (burst_left > 0) begin
          burst_left--;
        end
        if (burst_left == 0) begin
          // new burst; a quarter of them follow with no gap at all
          burst_left = $urandom_range(1, 48);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // command monitor and stall pattern
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    joint_cmds_t got;
    joint_cmds_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got = {left_fore_hip_cmd, right_fore_hip_cmd, left_hind_hip_cmd, right_hind_hip_cmd,
               left_fore_knee_cmd, right_fore_knee_cmd, left_hind_knee_cmd,
               right_hind_knee_cmd};
        if (due_cmds.size() == 0) begin
          report_mismatch("command set with no tick outstanding");
        end else begin
          want = due_cmds.pop_front();
          check_joint("lf_hip", got.lf_hip, want.lf_hip);
          check_joint("rf_hip", got.rf_hip, want.rf_hip);
          check_joint("lh_hip", got.lh_hip, want.lh_hip);
          check_joint("rh_hip", got.rh_hip, want.rh_hip);
          check_joint("lf_knee", got.lf_knee, want.lf_knee);
          check_joint("rf_knee", got.rf_knee, want.rf_knee);
          check_joint("lh_knee", got.lh_knee, want.lh_knee);
          check_joint("rh_knee", got.rh_knee, want.rh_knee);
        end
        cmds_checked++;
      end
      // back-pressure style is redrawn at random when its countdown runs out
      if (stall_left == 0) begin
        stall_mode = stall_mode_t'($urandom_range(0, 3));
        stall_left = $urandom_range(20, 300);
      end else begin
        stall_left--;
      end
      case (stall_mode)
        STALL_NONE:  out_stall <= 1'b0;
        STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        STALL_HALF:  out_stall <= ($urandom_range(0, 1) == 0);
        default:     out_stall <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------

  // register write; the shadow copy follows, bits above the width dropped
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_PHASE_STEP:    gait_cfg.phase_step      = data[STEP_W-1:0];
      REG_AMP_FORE_HIP:  gait_cfg.amp_fore_hip    = data[AMP_W-1:0];
      REG_AMP_HIND_HIP:  gait_cfg.amp_hind_hip    = data[AMP_W-1:0];
      REG_AMP_FORE_KNEE: gait_cfg.amp_fore_knee   = data[AMP_W-1:0];
      REG_AMP_HIND_KNEE: gait_cfg.amp_hind_knee   = data[AMP_W-1:0];
      REG_OFS_FORE_HIP:  gait_cfg.offset_fore_hip = data[OFS_W-1:0];
      REG_OFS_HIND_HIP:  gait_cfg.offset_hind_hip = data[OFS_W-1:0];
      default:           gait_cfg.knee_lag        = data[LAG_W-1:0];
    endcase
  endtask

  // everything sent and every command set back
  task automatic wait_idle();
    while (tick_queue.size() != 0 || in_valid || due_cmds.size() != 0) begin
      @(negedge clk);
    end
    settings_run++;
  endtask

  // register value of width w: extremes, small, or random, junk in the unused bits
  function automatic logic [CFG_DATA_W-1:0] pick_reg(int w, bit is_signed);
    logic [CFG_DATA_W-1:0] mask;
    logic [CFG_DATA_W-1:0] v;
    mask = 16'hFFFF >> (CFG_DATA_W - w);
    case ($urandom_range(0, 5))
      0: v = '0;
      1: v = is_signed ? (mask >> 1) : mask;
      2: v = is_signed ? (16'h1 << (w - 1)) : 16'h1;
      3: v = 16'($urandom_range(0, 15));
      default: v = 16'($urandom) & mask;
    endcase
    return v | (16'($urandom) & ~mask);
  endfunction

  task automatic push_ticks(int n, int restart_pct);
    for (int k = 0; k < n; k++) begin
      tick_queue.push_back($urandom_range(0, 99) < restart_pct);
    end
  endtask

  initial begin
    int left;
    int n;
    for (int k = 0; k <= COS_ENTRIES; k++) begin
      cos_tab[k] = quarter_cos(k);
    end
    gait_cfg.phase_step      = RST_PHASE_STEP;
    gait_cfg.amp_fore_hip    = RST_AMP_FORE_HIP;
    gait_cfg.amp_hind_hip    = RST_AMP_HIND_HIP;
    gait_cfg.amp_fore_knee   = RST_AMP_FORE_KNEE;
    gait_cfg.amp_hind_knee   = RST_AMP_HIND_KNEE;
    gait_cfg.offset_fore_hip = RST_OFS_FORE_HIP;
    gait_cfg.offset_hind_hip = RST_OFS_HIND_HIP;
    gait_cfg.knee_lag        = RST_KNEE_LAG;
    model_phase              = '0;

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset defaults, restart mid-run
    tick_queue = '{1'b0, 1'b0, 1'b0, 1'b1, 1'b0};
    wait_idle();

    // quarter-turn steps land on every quadrant boundary and the knee end point
    write_reg(REG_PHASE_STEP, 16'd16384);
    write_reg(REG_AMP_FORE_HIP, 16'd8191);
    write_reg(REG_AMP_HIND_HIP, 16'd8191);
    write_reg(REG_AMP_FORE_KNEE, 16'd8191);
    write_reg(REG_AMP_HIND_KNEE, 16'd8191);
    write_reg(REG_OFS_FORE_HIP, 16'h1FFF);
    write_reg(REG_OFS_HIND_HIP, 16'h2000);
    write_reg(REG_KNEE_LAG, 16'd0);
    tick_queue = '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0};
    wait_idle();

    // frozen phase, zero swing, lag exactly a half turn
    write_reg(REG_PHASE_STEP, 16'd0);
    write_reg(REG_AMP_FORE_HIP, 16'd0);
    write_reg(REG_AMP_HIND_HIP, 16'd0);
    write_reg(REG_AMP_FORE_KNEE, 16'd0);
    write_reg(REG_OFS_FORE_HIP, 16'd0);
    write_reg(REG_KNEE_LAG, 16'h8000);
    tick_queue = '{1'b1, 1'b0, 1'b0};
    wait_idle();

    // amplitude 2048 makes odd cosines fall on exact halves
    write_reg(REG_PHASE_STEP, 16'd12345);
    write_reg(REG_AMP_FORE_HIP, 16'd2048);
    write_reg(REG_AMP_HIND_HIP, 16'd1);
    write_reg(REG_AMP_HIND_KNEE, 16'd1);
    write_reg(REG_KNEE_LAG, 16'h7FFF);
    tick_queue = '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0};
    wait_idle();

    // largest step and lag, unused data bits set
    write_reg(REG_PHASE_STEP, 16'hFFFF);
    write_reg(REG_AMP_FORE_HIP, 16'hFFFF);
    write_reg(REG_OFS_FORE_HIP, 16'hE000);
    write_reg(REG_KNEE_LAG, 16'hFFFF);
    tick_queue = '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0};
    wait_idle();

    // random settings, each followed by a random run of ticks
    left = RANDOM_TICKS;
    while (left > 0) begin
      write_reg(REG_PHASE_STEP, pick_reg(STEP_W, 1'b0));
      write_reg(REG_AMP_FORE_HIP, pick_reg(AMP_W, 1'b0));
      write_reg(REG_AMP_HIND_HIP, pick_reg(AMP_W, 1'b0));
      write_reg(REG_AMP_FORE_KNEE, pick_reg(AMP_W, 1'b0));
      write_reg(REG_AMP_HIND_KNEE, pick_reg(AMP_W, 1'b0));
      write_reg(REG_OFS_FORE_HIP, pick_reg(OFS_W, 1'b1));
      write_reg(REG_OFS_HIND_HIP, pick_reg(OFS_W, 1'b1));
      write_reg(REG_KNEE_LAG, pick_reg(LAG_W, 1'b0));
      n = $urandom_range(100, 220);
      if (n > left) begin
        n = left;
      end
      push_ticks(n, 4);
      left -= n;
      wait_idle();
    end

    // let any stray command set show up
    repeat (8) @(negedge clk);

    $display("covered %0d ticks (%0d restarts) under %0d register settings",
             ticks_sent, restarts_sent, settings_run);
    $display("compared %0d command sets, %0d mismatches", cmds_checked, err_count);
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== sim.f =====
design/tgpg_pkg.sv
design/tgpg_cfg_regs.sv
design/tgpg_cos_lut.sv
design/tgpg_hip_pair.sv
design/trot_gait_pattern_generator_core.sv
bench/tb.sv
